[hdl/command_line_tokenizer_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the command line tokenizer
// Clocked concurrent assertions with asynchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// Property must hold at every rising edge outside reset.
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define CLT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/clt_pkg.sv]
// ---------------------------------------------------------------------------
// clt_pkg
// Shared types and character constants of the command line tokenizer.
// ---------------------------------------------------------------------------
package clt_pkg;

	// Parse phases
	typedef enum logic [2:0] {
		PH_LEAD = 3'd0, // skipping leading whitespace
		PH_EXEQ = 3'd1, // quoted executable name
		PH_EXEP = 3'd2, // plain executable name
		PH_GAP  = 3'd3, // whitespace between arguments
		PH_ARG  = 3'd4  // inside an argument
	} clt_phase_t;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// Token kinds
	localparam logic KIND_EXE = 1'b0;
	localparam logic KIND_ARG = 1'b1;

	// One result word
	typedef struct packed {
		logic [7:0] backslash_count;
		logic [7:0] char_code;
		logic       char_valid;
		logic       token_end;
		logic       token_kind;
		logic       string_end;
	} clt_result_t;

endpackage

[hdl/clt_parse.sv]
// ---------------------------------------------------------------------------
// clt_parse
// Parse state registers and the combinational step logic for one byte.
// ---------------------------------------------------------------------------
`include "command_line_tokenizer_assert.svh"

module clt_parse #(
	parameter int MAX_BACKSLASH_RUN = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,    // consume byte_in this cycle
	input  logic [7:0]           byte_in,
	output logic                 has_result,
	output clt_pkg::clt_result_t result
);

	localparam int RW = $clog2(MAX_BACKSLASH_RUN + 1);
	localparam int BW = (RW > 8) ? RW : 8;
	localparam logic [RW-1:0] RUN_MAX = RW'(MAX_BACKSLASH_RUN);
	localparam logic [BW-1:0] BS_CLAMP = BW'(255);

	clt_pkg::clt_phase_t phase_q, phase_d;
	logic                quoting_q, quoting_d;
	logic                pend_q, pend_d;
	logic [RW-1:0]       run_q, run_d;

	logic       in_arg;
	logic       use_run;
	logic       q_eff;
	logic       is_blank;
	logic [BW-1:0] n_ext;
	logic [BW-1:0] n_sel;

	logic       nul_step;
	logic       parse_idle;
	logic       run_stray;

	assign is_blank = (byte_in == clt_pkg::CH_SPACE) || (byte_in == clt_pkg::CH_TAB);

	// Next state and result for the byte at hand
	always_comb begin
		phase_d   = phase_q;
		quoting_d = quoting_q;
		pend_d    = pend_q;
		run_d     = run_q;
		in_arg    = 1'b0;
		use_run   = 1'b0;
		q_eff     = quoting_q;
		result    = '0;

		case (phase_q)
			clt_pkg::PH_EXEQ: begin
				if (byte_in == clt_pkg::CH_NUL) begin
					phase_d           = clt_pkg::PH_LEAD;
					result.token_end  = 1'b1;
					result.string_end = 1'b1;
				end else if (byte_in == clt_pkg::CH_QUOTE) begin
					phase_d          = clt_pkg::PH_GAP;
					result.token_end = 1'b1;
				end else begin
					result.char_code  = byte_in;
					result.char_valid = 1'b1;
				end
			end
			clt_pkg::PH_EXEP: begin
				if (byte_in == clt_pkg::CH_NUL) begin
					phase_d           = clt_pkg::PH_LEAD;
					result.token_end  = 1'b1;
					result.string_end = 1'b1;
				end else if (is_blank) begin
					phase_d          = clt_pkg::PH_GAP;
					result.token_end = 1'b1;
				end else begin
					result.char_code  = byte_in;
					result.char_valid = 1'b1;
				end
			end
			clt_pkg::PH_GAP: begin
				if (byte_in == clt_pkg::CH_NUL) begin
					phase_d           = clt_pkg::PH_LEAD;
					result.token_kind = clt_pkg::KIND_ARG;
					result.string_end = 1'b1;
				end else if (!is_blank) begin
					phase_d = clt_pkg::PH_ARG;
					in_arg  = 1'b1;
				end
			end
			clt_pkg::PH_ARG: begin
				in_arg = 1'b1;
			end
			default: begin
				if (byte_in == clt_pkg::CH_NUL) begin
					phase_d           = clt_pkg::PH_LEAD;
					result.token_end  = 1'b1;
					result.string_end = 1'b1;
				end else if (is_blank) begin
					phase_d = clt_pkg::PH_LEAD;
				end else if (byte_in == clt_pkg::CH_QUOTE) begin
					phase_d = clt_pkg::PH_EXEQ;
				end else begin
					phase_d           = clt_pkg::PH_EXEP;
					result.char_code  = byte_in;
					result.char_valid = 1'b1;
				end
			end
		endcase

		// Argument rules: backslash runs, quoting, doubled quotes
		if (in_arg) begin
			result.token_kind = clt_pkg::KIND_ARG;
			if (pend_q && byte_in == clt_pkg::CH_QUOTE) begin
				// doubled quote inside quotes
				pend_d            = 1'b0;
				result.char_code  = byte_in;
				result.char_valid = 1'b1;
			end else begin
				if (pend_q) begin
					pend_d    = 1'b0;
					quoting_d = 1'b0;
					q_eff     = 1'b0;
				end
				if (byte_in == clt_pkg::CH_BSL) begin
					if (run_q < RUN_MAX)
						run_d = run_q + 1'b1;
				end else begin
					run_d   = '0;
					use_run = 1'b1;
					if (byte_in == clt_pkg::CH_QUOTE) begin
						if (!run_q[0]) begin
							if (q_eff)
								pend_d = 1'b1;
							else
								quoting_d = 1'b1;
						end else begin
							result.char_code  = byte_in;
							result.char_valid = 1'b1;
						end
					end else if (byte_in == clt_pkg::CH_NUL) begin
						phase_d           = clt_pkg::PH_LEAD;
						quoting_d         = 1'b0;
						pend_d            = 1'b0;
						result.token_end  = 1'b1;
						result.string_end = 1'b1;
					end else if (is_blank && !q_eff) begin
						phase_d          = clt_pkg::PH_GAP;
						result.token_end = 1'b1;
					end else begin
						result.char_code  = byte_in;
						result.char_valid = 1'b1;
					end
				end
			end
		end

		// Pending backslashes, halved before a quote, clamped to a byte
		if (use_run) begin
			if (n_sel > BS_CLAMP)
				result.backslash_count = 8'hFF;
			else
				result.backslash_count = n_sel[7:0];
		end
	end

	assign n_ext = BW'(run_q);
	assign n_sel = (byte_in == clt_pkg::CH_QUOTE) ? (n_ext >> 1) : n_ext;

	assign has_result = (result.backslash_count != 8'd0) || result.char_valid ||
		result.token_end || result.string_end;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= clt_pkg::PH_LEAD;
			quoting_q <= 1'b0;
			pend_q    <= 1'b0;
			run_q     <= '0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			quoting_q <= quoting_d;
			pend_q    <= pend_d;
			run_q     <= run_d;
		end
	end

	// Checks
	assign nul_step   = step_en && (byte_in == clt_pkg::CH_NUL);
	assign parse_idle = (phase_q == clt_pkg::PH_LEAD) && !quoting_q && !pend_q && (run_q == '0);
	assign run_stray  = (run_q != '0) && (phase_q != clt_pkg::PH_ARG);

	`CLT_ASSERT(a_nul_resets, clk, arst_n, nul_step |=> parse_idle, "zero byte left parser busy")
	`CLT_NEVER(a_pend_needs_quoting, clk, arst_n, pend_q && !quoting_q, "quote pending unquoted")
	`CLT_NEVER(a_run_only_in_arg, clk, arst_n, run_stray, "backslash run held outside an argument")

endmodule

[hdl/clt_out_stage.sv]
// ---------------------------------------------------------------------------
// clt_out_stage
// Result register with stream handshake toward the consumer.
// ---------------------------------------------------------------------------
module clt_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid, // a word is offered for loading
	input  clt_pkg::clt_result_t load_word,
	output logic                 can_load,   // register free after this edge
	output logic                 tvalid,
	input  logic                 tready,
	output clt_pkg::clt_result_t word
);

	logic                 valid_s2;
	clt_pkg::clt_result_t word_s2;

	assign can_load = !valid_s2 || tready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (can_load)
			valid_s2 <= load_valid;
	end

	// Payload
	always_ff @(posedge clk) begin
		if (can_load && load_valid)
			word_s2 <= load_word;
	end

	assign tvalid = valid_s2;
	assign word   = word_s2;

endmodule

[hdl/command_line_tokenizer.sv]
// ---------------------------------------------------------------------------
// command_line_tokenizer
// Splits a zero-terminated command line into executable and argument tokens.
// ---------------------------------------------------------------------------
// Takes one byte per cycle, back to back, while the output is not stalled, and
// gives at most one word per byte; each word passes the input register, then
// the result register, before it is valid on the output.
// The rate is set by the combinational parse step that updates phase, quoting and
// backslash run state for every byte. Bytes that only extend a backslash run
// or skip whitespace give no word. A zero byte ends the line with string_end
// set (tlast) and the parser is ready for a new line at the next byte.
// Backslash runs count up to MAX_BACKSLASH_RUN; the count on the output is
// clamped to 255.
module command_line_tokenizer #(
	parameter int MAX_BACKSLASH_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] backslash_count, [15:8] char_code
	output logic        m_tlast,  // string_end
	output logic [2:0]  m_tuser   // [0] char_valid, [1] token_end, [2] token_kind
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 can_load;
	logic                 step_en;
	logic                 has_result;
	clt_pkg::clt_result_t result;
	clt_pkg::clt_result_t out_word;

	// Input stage moves on whenever the result register can take its word
	assign step_en  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	clt_parse #(
		.MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.byte_in   (byte_s1),
		.has_result(has_result),
		.result    (result)
	);

	clt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(valid_s1 && has_result),
		.load_word (result),
		.can_load  (can_load),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.word      (out_word)
	);

	// Output packing
	assign m_tdata = {out_word.char_code, out_word.backslash_count};
	assign m_tlast = out_word.string_end;
	assign m_tuser = {out_word.token_kind, out_word.token_end, out_word.char_valid};

endmodule

[test/command_line_tokenizer_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_line_tokenizer_checker
// Watches both stream channels of the tokenizer and checks every result word.
// ---------------------------------------------------------------------------
// Each byte taken on the input channel runs through a local copy of the
// tokenizer rules. A byte that yields a word queues the expected word. Every
// word taken on the output channel is compared with the oldest expected one.
// The failure count and the number of expected words still outstanding are
// handed to the testbench top.
module command_line_tokenizer_checker #(
	parameter int MAX_BACKSLASH_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // [7:0] backslash_count, [15:8] char_code
	input  logic        m_tlast,  // string_end
	input  logic [2:0]  m_tuser,  // [0] char_valid, [1] token_end, [2] token_kind
	output int          fail_count,
	output int          outstanding
);

	// Local parser state
	clt_pkg::clt_phase_t  phase;
	logic                 in_quotes;
	logic                 quote_wait;
	int                   bs_run;
	clt_pkg::clt_result_t token_words[$];
	int                   fail_cnt = 0;

	function automatic bit is_blank(input logic [7:0] c);
		return c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB;
	endfunction

	// Builds a word; returns 0 when it would carry nothing
	function automatic bit make_word(input int bs, input logic [7:0] ch, input logic valid,
			input logic tend, input logic kind, input logic send,
			output clt_pkg::clt_result_t w);
		w.backslash_count = (bs > 255) ? 8'd255 : 8'(bs);
		w.char_code       = valid ? ch : clt_pkg::CH_NUL;
		w.char_valid      = valid;
		w.token_end       = tend;
		w.token_kind      = kind;
		w.string_end      = send;
		return bs != 0 || valid || tend || send;
	endfunction

	// Back to the start of a new command line
	function void restart_line();
		phase      = clt_pkg::PH_LEAD;
		in_quotes  = 1'b0;
		quote_wait = 1'b0;
		bs_run     = 0;
	endfunction

	// One byte through the tokenizer rules; returns 1 if a word results
	function automatic bit tokenize_byte(input logic [7:0] c, output clt_pkg::clt_result_t w);
		int n;
		w = '0;
		case (phase)
			clt_pkg::PH_EXEQ: begin
				if (c == clt_pkg::CH_NUL) begin
					restart_line();
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_EXE,
						1'b1, w);
				end
				if (c == clt_pkg::CH_QUOTE) begin
					phase = clt_pkg::PH_GAP;
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_EXE,
						1'b0, w);
				end
				return make_word(0, c, 1'b1, 1'b0, clt_pkg::KIND_EXE, 1'b0, w);
			end
			clt_pkg::PH_EXEP: begin
				if (c == clt_pkg::CH_NUL) begin
					restart_line();
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_EXE,
						1'b1, w);
				end
				if (is_blank(c)) begin
					phase = clt_pkg::PH_GAP;
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_EXE,
						1'b0, w);
				end
				return make_word(0, c, 1'b1, 1'b0, clt_pkg::KIND_EXE, 1'b0, w);
			end
			clt_pkg::PH_GAP: begin
				if (c == clt_pkg::CH_NUL) begin
					restart_line();
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b0, clt_pkg::KIND_ARG,
						1'b1, w);
				end
				if (is_blank(c))
					return 1'b0;
				phase = clt_pkg::PH_ARG;
			end
			clt_pkg::PH_ARG: ;
			default: begin
				phase = clt_pkg::PH_LEAD;
				if (c == clt_pkg::CH_NUL) begin
					restart_line();
					return make_word(0, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_EXE,
						1'b1, w);
				end
				if (is_blank(c))
					return 1'b0;
				if (c == clt_pkg::CH_QUOTE) begin
					phase = clt_pkg::PH_EXEQ;
					return 1'b0;
				end
				phase = clt_pkg::PH_EXEP;
				return make_word(0, c, 1'b1, 1'b0, clt_pkg::KIND_EXE, 1'b0, w);
			end
		endcase

		// Inside an argument: a quote after a closing quote is literal
		if (quote_wait) begin
			quote_wait = 1'b0;
			if (c == clt_pkg::CH_QUOTE)
				return make_word(0, c, 1'b1, 1'b0, clt_pkg::KIND_ARG, 1'b0, w);
			in_quotes = 1'b0;
		end
		if (c == clt_pkg::CH_BSL) begin
			if (bs_run < MAX_BACKSLASH_RUN)
				bs_run++;
			return 1'b0;
		end
		n      = bs_run;
		bs_run = 0;
		if (c == clt_pkg::CH_QUOTE) begin
			// even run toggles quoting, odd run escapes the quote
			if (n[0] == 1'b0) begin
				if (in_quotes)
					quote_wait = 1'b1;
				else
					in_quotes = 1'b1;
				return make_word(n >> 1, clt_pkg::CH_NUL, 1'b0, 1'b0, clt_pkg::KIND_ARG,
					1'b0, w);
			end
			return make_word(n >> 1, c, 1'b1, 1'b0, clt_pkg::KIND_ARG, 1'b0, w);
		end
		if (c == clt_pkg::CH_NUL) begin
			restart_line();
			return make_word(n, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_ARG, 1'b1, w);
		end
		if (is_blank(c) && !in_quotes) begin
			phase = clt_pkg::PH_GAP;
			return make_word(n, clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::KIND_ARG, 1'b0, w);
		end
		return make_word(n, c, 1'b1, 1'b0, clt_pkg::KIND_ARG, 1'b0, w);
	endfunction

	function void report_word(input string what, input clt_pkg::clt_result_t want,
			input clt_pkg::clt_result_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display({"%t: %s: expected bs=%0d ch=%02h v=%b end=%b kind=%b last=%b,",
				" got bs=%0d ch=%02h v=%b end=%b kind=%b last=%b"},
				$time, what, want.backslash_count, want.char_code, want.char_valid,
				want.token_end, want.token_kind, want.string_end,
				got.backslash_count, got.char_code, got.char_valid,
				got.token_end, got.token_kind, got.string_end);
	endfunction

	// Compare output words first, then predict from the byte taken this edge
	always @(posedge clk or negedge arst_n) begin : watch
		clt_pkg::clt_result_t got;
		clt_pkg::clt_result_t want;
		if (!arst_n) begin
			restart_line();
			token_words.delete();
			outstanding <= 0;
			fail_count  <= fail_cnt;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{backslash_count: m_tdata[7:0], char_code: m_tdata[15:8],
					char_valid: m_tuser[0], token_end: m_tuser[1],
					token_kind: m_tuser[2], string_end: m_tlast};
				if (token_words.size() == 0)
					report_word("unexpected word", '0, got);
				else begin
					want = token_words.pop_front();
					if (got !== want)
						report_word("word mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				if (tokenize_byte(s_tdata, want))
					token_words.push_back(want);
			end
			fail_count  <= fail_cnt;
			outstanding <= token_words.size();
		end
	end

endmodule

[test/command_line_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_line_tokenizer_tb
// Stimulus and verdict for the command line tokenizer.
// ---------------------------------------------------------------------------
// Feeds a few hand-made command lines covering the quoting and backslash
// rules, then random lines: mostly well-formed executables and arguments
// with random content, some broken or pure noise, and a few very long
// backslash runs near or past the counter bound. Both sides idle at random,
// the receiver holds off once for a long stretch, and the sender pauses once
// until every word has drained. The checker module does all comparison.
module command_line_tokenizer_tb;

	localparam int NUM_BYTES   = 1250;
	localparam int HOLD_CYCLES = 200;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	int          fail_count;
	int          outstanding;
	int          bytes_sent = 0;
	bit          src_gaps   = 1'b1;
	bit          sink_gaps  = 1'b1;
	bit          hold_req   = 1'b0;
	bit          long_done  = 1'b0;
	logic [7:0]  line_q[$];

	command_line_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	command_line_tokenizer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin : sink
		int hold_left;
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
					@(posedge clk);
			end else
				m_tready <= !(sink_gaps && $urandom_range(0, 99) < 20);
		end
	end

	initial begin
		#(2_000_000);
		$display("command_line_tokenizer_tb: errors");
		$finish;
	end

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB;
	endfunction

	// Mostly lowercase letters, sometimes any nonzero byte
	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 9) < 7)
			return 8'(8'h61 + $urandom_range(0, 25));
		return 8'($urandom_range(1, 255));
	endfunction

	function void add_arg_piece();
		case ($urandom_range(0, 9))
			0, 1, 2: line_q.push_back(text_char());
			3: line_q.push_back(8'($urandom_range(1, 255)));
			4, 5: begin
				repeat ($urandom_range(1, 5))
					line_q.push_back(clt_pkg::CH_BSL);
				if ($urandom_range(0, 9) < 7)
					line_q.push_back(clt_pkg::CH_QUOTE);
			end
			6: line_q.push_back(clt_pkg::CH_QUOTE);
			7: begin
				line_q.push_back(clt_pkg::CH_QUOTE);
				line_q.push_back(clt_pkg::CH_QUOTE);
			end
			8: line_q.push_back(clt_pkg::CH_SPACE);
			default: line_q.push_back(clt_pkg::CH_TAB);
		endcase
	endfunction

	// One random command line, zero-terminated
	function void build_line();
		int r;
		line_q.delete();
		r = $urandom_range(0, 99);
		// noise line, zeros allowed anywhere
		if (r < 8) begin
			repeat ($urandom_range(1, 12))
				line_q.push_back(8'($urandom_range(0, 255)));
			line_q.push_back(clt_pkg::CH_NUL);
			return;
		end
		repeat ($urandom_range(0, 2))
			line_q.push_back(blank_char());
		r = $urandom_range(0, 9);
		if (r >= 1 && r <= 4) begin
			// quoted executable, closing quote sometimes missing
			line_q.push_back(clt_pkg::CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 5))
					0: line_q.push_back(clt_pkg::CH_BSL);
					1: line_q.push_back(clt_pkg::CH_SPACE);
					default: line_q.push_back(text_char());
				endcase
			end
			if ($urandom_range(0, 9) != 0)
				line_q.push_back(clt_pkg::CH_QUOTE);
		end else if (r >= 5) begin
			repeat ($urandom_range(1, 6))
				line_q.push_back(text_char());
		end
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 4) != 0)
				repeat ($urandom_range(1, 2))
					line_q.push_back(blank_char());
			// long run near or past the counter bound
			if (!long_done || $urandom_range(0, 149) == 0) begin
				long_done = 1'b1;
				repeat ($urandom_range(250, 300))
					line_q.push_back(clt_pkg::CH_BSL);
				line_q.push_back($urandom_range(0, 1) ? clt_pkg::CH_QUOTE : text_char());
			end
			repeat ($urandom_range(1, 6))
				add_arg_piece();
		end
		if ($urandom_range(0, 3) == 0)
			line_q.push_back(blank_char());
		line_q.push_back(clt_pkg::CH_NUL);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (src_gaps && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_byte(line_q[i]);
	endtask

	// Stop sending until every expected word has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		bit hold_done;
		bit pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty executable
		line_q = '{clt_pkg::CH_NUL};
		send_line();
		// leading whitespace, plain executable with a high byte, ended by zero
		line_q = '{clt_pkg::CH_TAB, "a", 8'hFF, clt_pkg::CH_NUL};
		send_line();
		// quoted executable with plain backslash, argument right after the
		// closing quote, quote pair then zero
		line_q = '{clt_pkg::CH_QUOTE, clt_pkg::CH_BSL, clt_pkg::CH_SPACE, clt_pkg::CH_QUOTE,
			"x", clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE, clt_pkg::CH_NUL};
		send_line();
		// even and odd backslash runs, doubled quote inside quotes, run kept
		// whole before a tab, empty argument, string end between arguments
		line_q = '{"e", clt_pkg::CH_SPACE, clt_pkg::CH_BSL, clt_pkg::CH_BSL,
			clt_pkg::CH_QUOTE, clt_pkg::CH_BSL, clt_pkg::CH_BSL, clt_pkg::CH_BSL,
			clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE,
			clt_pkg::CH_BSL, clt_pkg::CH_TAB, clt_pkg::CH_QUOTE, clt_pkg::CH_QUOTE,
			clt_pkg::CH_SPACE, clt_pkg::CH_NUL};
		send_line();

		// random lines
		while (bytes_sent < NUM_BYTES) begin
			src_gaps  = !(bytes_sent >= 450 && bytes_sent < 650);
			sink_gaps = src_gaps;
			if (!hold_done && bytes_sent >= 300) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && bytes_sent >= 800) begin
				drain();
				pause_done = 1'b1;
			end
			build_line();
			send_line();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("command_line_tokenizer_tb: clean");
		else
			$display("command_line_tokenizer_tb: errors");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/clt_pkg.sv
hdl/clt_parse.sv
hdl/clt_out_stage.sv
hdl/command_line_tokenizer.sv
test/command_line_tokenizer_checker.sv
test/command_line_tokenizer_tb.sv
